/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion shorthands, sampled on clk, off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/pfr_pkg.sv */
// ----------------------------------------------------------------------------
// pfr_pkg
// shared types and constants of the packet frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

	localparam int DEST_POS      = 0;
	localparam int LEN_POS       = 1;
	localparam int DEST_CHECK_AT = 2;
	localparam int BANK_SIZE     = 256;
	localparam int BANK_AW       = 8;
	localparam int PAYLOAD_DEPTH = 2 * BANK_SIZE;
	localparam int SKIP_W        = 9;
	localparam int RIDX_W        = 9;
	localparam int POSF_W        = 3;
	localparam int CFG_IW        = 3;

	localparam logic [CFG_IW-1:0] REG_OWN_ADDR    = 3'd0;
	localparam logic [CFG_IW-1:0] REG_BCAST_ADDR  = 3'd1;
	localparam logic [CFG_IW-1:0] REG_CHECK_CODE  = 3'd2;
	localparam logic [CFG_IW-1:0] REG_STATUS_POS  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_SOURCE_POS  = 3'd4;

	typedef enum logic [1:0] {
		A_BYTE    = 2'd0,
		A_RELEASE = 2'd1,
		A_READ    = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		V_NONE    = 3'd0,
		V_HELD    = 3'd1,
		V_CHECK   = 3'd2,
		V_FULL    = 3'd3,
		V_INVALID = 3'd4
	} verdict_t;

	typedef struct packed {
		logic [7:0]        own_addr;
		logic [7:0]        bcast_addr;
		logic [7:0]        check_code;
		logic [POSF_W-1:0] status_pos;
		logic [POSF_W-1:0] source_pos;
	} cfg_t;

	typedef struct packed {
		verdict_t          verdict;
		logic [SKIP_W-1:0] skip_count;
		logic [7:0]        source_address;
		logic              held_valid;
		logic [7:0]        read_byte;
		logic              read_empty;
	} res_t;

endpackage

`default_nettype wire

/* rtl/core/pfr_ram.sv */
// ----------------------------------------------------------------------------
// pfr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/pfr_frame.sv */
// ----------------------------------------------------------------------------
// pfr_frame
// frame parser, held slot and banked payload store; while take is high, one word per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_frame import pfr_pkg::*; #(
	parameter int HEADER_BYTES = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              take,
	input  wire action_t           action,
	input  wire logic [7:0]        data_byte,
	input  wire logic              line_error,
	input  wire logic [RIDX_W-1:0] read_index,
	output      res_t              res
);

	localparam int POS_W = $clog2(HEADER_BYTES + BANK_SIZE);
	localparam int RAM_AW = $clog2(PAYLOAD_DEPTH);

	logic [POS_W-1:0] pos_q, pos_n;
	logic [7:0]       hdr_q [HEADER_BYTES];
	logic [7:0]       hdr_n [HEADER_BYTES];
	logic [7:0]       held_hdr_q [HEADER_BYTES];
	logic [7:0]       xor_q, xor_n;
	logic             held_q, held_n;
	logic             bank_q, bank_n;
	logic             copy;

	logic              bad;
	logic [7:0]        len;
	logic [7:0]        status_b;
	logic [7:0]        source_b;
	logic [POS_W-1:0]  pay_off;
	logic [RIDX_W-1:0] ridx_off;
	logic              ram_we, ram_re;
	logic [7:0]        ram_rdata;

	verdict_t          verdict;
	logic [SKIP_W-1:0] skip;
	logic [7:0]        src;
	logic [7:0]        hdr_rd;
	logic              rd_ram;
	logic              rempty;

	verdict_t          verdict_s1;
	logic [SKIP_W-1:0] skip_s1;
	logic [7:0]        src_s1;
	logic              held_s1;
	logic [7:0]        hdr_rd_s1;
	logic              rd_ram_s1;
	logic              rempty_s1;

	assign pay_off  = pos_q - POS_W'(HEADER_BYTES);
	assign ridx_off = read_index - RIDX_W'(HEADER_BYTES);

	always_comb begin
		hdr_n    = hdr_q;
		xor_n    = xor_q;
		pos_n    = pos_q;
		held_n   = held_q;
		bank_n   = bank_q;
		copy     = 1'b0;
		bad      = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		verdict  = V_NONE;
		skip     = '0;
		src      = '0;
		hdr_rd   = '0;
		rd_ram   = 1'b0;
		rempty   = 1'b0;
		status_b = '0;
		source_b = '0;
		len      = hdr_q[LEN_POS];
		unique case (action)
			A_BYTE: begin
				bad = line_error;
				if (!line_error) begin
					if (pos_q < POS_W'(HEADER_BYTES)) begin
						for (int i = 0; i < HEADER_BYTES; i++) begin
							if (int'(pos_q) == i) begin
								hdr_n[i] = data_byte;
							end
						end
						xor_n = (pos_q == '0) ? data_byte : (xor_q ^ data_byte);
						pos_n = pos_q + POS_W'(1);
						if (pos_n == POS_W'(DEST_CHECK_AT)) begin
							if (hdr_q[DEST_POS] != cfg.own_addr &&
									hdr_q[DEST_POS] != cfg.bcast_addr) begin
								bad = 1'b1;
							end
						end else if (pos_n == POS_W'(HEADER_BYTES)) begin
							if (xor_n != 8'd0) begin
								bad = 1'b1;
							end
						end
					end else if (pay_off < POS_W'(hdr_q[LEN_POS])) begin
						ram_we = 1'b1;
						pos_n  = pos_q + POS_W'(1);
					end
				end
				len = hdr_n[LEN_POS];
				for (int i = 0; i < HEADER_BYTES; i++) begin
					if (int'(cfg.status_pos) == i) begin
						status_b = hdr_n[i];
					end
					if (int'(cfg.source_pos) == i) begin
						source_b = hdr_n[i];
					end
				end
				if (bad) begin
					verdict = V_INVALID;
					skip    = SKIP_W'(POS_W'(HEADER_BYTES) + POS_W'(len) - pos_n);
					pos_n   = '0;
				end else if (pos_n == POS_W'(HEADER_BYTES) + POS_W'(len)) begin
					src   = source_b;
					pos_n = '0;
					if (status_b == cfg.check_code) begin
						verdict = V_CHECK;
					end else if (!held_q) begin
						verdict = V_HELD;
						copy    = 1'b1;
						bank_n  = ~bank_q;
						held_n  = 1'b1;
					end else begin
						verdict = V_FULL;
					end
				end
			end
			A_RELEASE: begin
				held_n = 1'b0;
			end
			A_READ: begin
				if (!held_q) begin
					rempty = 1'b1;
				end else if (read_index < RIDX_W'(HEADER_BYTES)) begin
					for (int i = 0; i < HEADER_BYTES; i++) begin
						if (int'(read_index) == i) begin
							hdr_rd = held_hdr_q[i];
						end
					end
				end else if (ridx_off < RIDX_W'(held_hdr_q[LEN_POS])) begin
					rd_ram = 1'b1;
					ram_re = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			xor_q  <= '0;
			held_q <= 1'b0;
			bank_q <= 1'b0;
			for (int i = 0; i < HEADER_BYTES; i++) begin
				hdr_q[i] <= '0;
			end
		end else if (take) begin
			pos_q  <= pos_n;
			xor_q  <= xor_n;
			held_q <= held_n;
			bank_q <= bank_n;
			hdr_q  <= hdr_n;
		end
	end

	// held header copy and stage 1 result, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			if (copy) begin
				held_hdr_q <= hdr_n;
			end
			verdict_s1 <= verdict;
			skip_s1    <= skip;
			src_s1     <= src;
			held_s1    <= held_n;
			hdr_rd_s1  <= hdr_rd;
			rd_ram_s1  <= rd_ram;
			rempty_s1  <= rempty;
		end
	end

	// receive bank and held bank never coincide, so no forwarding
	pfr_ram #(
		.WIDTH (8),
		.DEPTH (PAYLOAD_DEPTH)
	) u_payload (
		.clk   (clk),
		.we    (take && ram_we),
		.waddr (RAM_AW'({bank_q, pay_off[BANK_AW-1:0]})),
		.wdata (data_byte),
		.re    (take && ram_re),
		.raddr (RAM_AW'({~bank_q, ridx_off[BANK_AW-1:0]})),
		.rdata (ram_rdata)
	);

	always_comb begin
		res.verdict        = verdict_s1;
		res.skip_count     = skip_s1;
		res.source_address = src_s1;
		res.held_valid     = held_s1;
		res.read_byte      = rd_ram_s1 ? ram_rdata : hdr_rd_s1;
		res.read_empty     = rempty_s1;
	end

endmodule

`default_nettype wire

/* rtl/core/packet_frame_receiver.sv */
// ----------------------------------------------------------------------------
// packet_frame_receiver
// byte-wise packet receiver with address and header checks and a held slot
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata, s_tuser (action)
//   m_*      out  m_tvalid/m_tready  m_tdata, m_tuser (verdict)
//   cfg_*    in   cfg_we             cfg_index, cfg_wdata
//
// one word per cycle while s_tready is high; m_tvalid rises once the result has
// passed the stage 1 registers and then the output register; m_tready can stall it between
// two stages: registered payload ram read, then the output register
// arst_n clears parse state, held flag, bank select and valid flags, and loads config defaults
// a stalled output holds one result and admits one more word
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module packet_frame_receiver import pfr_pkg::*; #(
	parameter int HEADER_BYTES = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output      logic              s_tready,
	input  wire logic [23:0]       s_tdata,   // data_byte, line_error, read_index, zero fill
	input  wire logic [1:0]        s_tuser,   // action
	output      logic              m_tvalid,
	input  wire logic              m_tready,
	output      logic [31:0]       m_tdata,   // skip_count, source_address, held_valid,
	                                          // read_byte, read_empty, zero fill
	output      logic [2:0]        m_tuser,   // verdict
	input  wire logic              cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [7:0]        cfg_wdata
);

	cfg_t cfg_q;
	res_t res;
	res_t res_s2;
	logic vld_s1, vld_s2;
	logic adv_s1;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_addr   <= 8'd0;
			cfg_q.bcast_addr <= 8'd255;
			cfg_q.check_code <= 8'd0;
			cfg_q.status_pos <= POSF_W'(3);
			cfg_q.source_pos <= POSF_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OWN_ADDR:   cfg_q.own_addr   <= cfg_wdata;
				REG_BCAST_ADDR: cfg_q.bcast_addr <= cfg_wdata;
				REG_CHECK_CODE: cfg_q.check_code <= cfg_wdata;
				REG_STATUS_POS: cfg_q.status_pos <= cfg_wdata[POSF_W-1:0];
				REG_SOURCE_POS: cfg_q.source_pos <= cfg_wdata[POSF_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv_s1   = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || adv_s1;
	assign take     = s_tvalid && s_tready;

	pfr_frame #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.take       (take),
		.action     (action_t'(s_tuser)),
		.data_byte  (s_tdata[7:0]),
		.line_error (s_tdata[8]),
		.read_index (s_tdata[17:9]),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (adv_s1) begin
				vld_s1 <= 1'b0;
			end
			if (adv_s1) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && vld_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tuser  = res_s2.verdict;
	assign m_tdata  = {5'd0, res_s2.read_empty, res_s2.read_byte, res_s2.held_valid,
		res_s2.source_address, res_s2.skip_count};

	`ASSERT_IMP(a_stall_blocks_in, vld_s1 && vld_s2 && !m_tready, !s_tready)
	`ASSERT_NXT(a_take_fills_s1, take, vld_s1)
	`ASSERT_IMP(a_held_sets_flag, vld_s2 && res_s2.verdict == V_HELD, res_s2.held_valid)
	`ASSERT_IMP(a_empty_reads_zero, vld_s2 && res_s2.read_empty,
		res_s2.read_byte == 8'd0 && !res_s2.held_valid)

endmodule

`default_nettype wire
